// ----- src/dmc_pkg.sv -----
`default_nettype none
package dmc_pkg;

  localparam int unsigned LINE_BYTES_DEF = 32;
  localparam int unsigned NUM_LINES_DEF  = 128;

  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned OFF_FW   = 5;
  localparam int unsigned BLK_FW   = 27;
  localparam int unsigned IDX_FW   = 7;
  localparam int unsigned TAG_FW   = 20;
  localparam int unsigned XFER_FW  = 6;
  localparam int unsigned CNT_W    = 32;

  localparam logic ACC_READ  = 1'b0;
  localparam logic ACC_WRITE = 1'b1;

  typedef struct packed {
    logic [ADDR_W-1:0] address;
    logic              access_kind;
  } in_t;

  typedef struct packed {
    logic [OFF_FW-1:0]  byte_offset;
    logic [BLK_FW-1:0]  block_number;
    logic [IDX_FW-1:0]  line_index;
    logic [TAG_FW-1:0]  tag;
    logic               miss;
    logic               replaced;
    logic [TAG_FW-1:0]  evicted_tag;
    logic               mem_read;
    logic               mem_write;
    logic [XFER_FW-1:0] transfer_bytes;
    logic [CNT_W-1:0]   hit_count;
    logic [CNT_W-1:0]   miss_count;
  } out_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;  // latch access, start tag read
    logic commit;   // tag data ready: decide, update, emit result
  } ctl_cmd_t;

endpackage
`default_nettype wire

// ----- src/dmc_ram.sv -----
`default_nettype none
module dmc_ram #(
  parameter int unsigned WIDTH = 20,
  parameter int unsigned DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- src/dmc_ctrl.sv -----
`default_nettype none
module dmc_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  output dmc_pkg::ctl_cmd_t      cmd
);

  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_LOOKUP = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt   = state_r;
    busy        = 1'b0;
    cmd.capture = 1'b0;
    cmd.commit  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        busy       = 1'b1;
        cmd.commit = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- src/dmc_datapath.sv -----
`default_nettype none
module dmc_datapath #(
  parameter int unsigned LINE_BYTES = dmc_pkg::LINE_BYTES_DEF,
  parameter int unsigned NUM_LINES  = dmc_pkg::NUM_LINES_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire dmc_pkg::ctl_cmd_t cmd,
  input  wire dmc_pkg::in_t      in_data,
  output logic                   out_valid,
  output dmc_pkg::out_t          out_data
);

  localparam int unsigned OFF_W = $clog2(LINE_BYTES);
  localparam int unsigned IDX_W = $clog2(NUM_LINES);
  localparam int unsigned TAG_W = dmc_pkg::ADDR_W - OFF_W - IDX_W;
  localparam int unsigned AW    = dmc_pkg::ADDR_W;

  logic [AW-1:0]              addr_r;
  logic                       kind_r;
  logic [NUM_LINES-1:0]       valid_r, valid_nxt;
  logic [dmc_pkg::CNT_W-1:0]  hit_cnt_r, hit_cnt_nxt;
  logic [dmc_pkg::CNT_W-1:0]  miss_cnt_r, miss_cnt_nxt;
  logic                       out_valid_r;
  dmc_pkg::out_t              out_r, out_nxt;

  logic [IDX_W-1:0] rd_idx;
  logic [IDX_W-1:0] idx;
  logic [TAG_W-1:0] tag_a;
  logic [TAG_W-1:0] tag_q;
  logic             vld;
  logic             hit;
  logic             rd_miss;

  assign rd_idx  = in_data.address[OFF_W +: IDX_W];
  assign idx     = addr_r[OFF_W +: IDX_W];
  assign tag_a   = addr_r[AW-1 -: TAG_W];
  assign vld     = valid_r[idx];
  assign hit     = vld && (tag_q == tag_a);
  assign rd_miss = !hit && (kind_r == dmc_pkg::ACC_READ);

  dmc_ram #(
    .WIDTH (TAG_W),
    .DEPTH (NUM_LINES)
  ) u_tag_ram (
    .clk   (clk),
    .we    (cmd.commit && rd_miss),
    .waddr (idx),
    .wdata (tag_a),
    .raddr (rd_idx),
    .rdata (tag_q)
  );

  always_comb begin
    valid_nxt    = valid_r;
    hit_cnt_nxt  = hit_cnt_r;
    miss_cnt_nxt = miss_cnt_r;
    if (hit) begin
      hit_cnt_nxt = hit_cnt_r + 1'b1;
    end else begin
      miss_cnt_nxt = miss_cnt_r + 1'b1;
    end
    if (rd_miss) begin
      valid_nxt[idx] = 1'b1;
    end

    out_nxt.byte_offset  = dmc_pkg::OFF_FW'(addr_r[OFF_W-1:0]);
    out_nxt.block_number = dmc_pkg::BLK_FW'(addr_r[AW-1:OFF_W]);
    out_nxt.line_index   = dmc_pkg::IDX_FW'(idx);
    out_nxt.tag          = dmc_pkg::TAG_FW'(tag_a);
    out_nxt.miss         = !hit;
    out_nxt.replaced     = rd_miss && vld;
    out_nxt.evicted_tag  = (rd_miss && vld) ? dmc_pkg::TAG_FW'(tag_q) : '0;
    out_nxt.mem_read     = rd_miss;
    out_nxt.mem_write    = (kind_r == dmc_pkg::ACC_WRITE);
    if (kind_r == dmc_pkg::ACC_WRITE) begin
      out_nxt.transfer_bytes = dmc_pkg::XFER_FW'(1);
    end else if (!hit) begin
      out_nxt.transfer_bytes = dmc_pkg::XFER_FW'(LINE_BYTES);
    end else begin
      out_nxt.transfer_bytes = '0;
    end
    out_nxt.hit_count  = hit_cnt_nxt;
    out_nxt.miss_count = miss_cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      addr_r <= in_data.address;
      kind_r <= in_data.access_kind;
    end
    if (cmd.commit) begin
      out_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      hit_cnt_r   <= '0;
      miss_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.commit;
      if (cmd.commit) begin
        valid_r    <= valid_nxt;
        hit_cnt_r  <= hit_cnt_nxt;
        miss_cnt_r <= miss_cnt_nxt;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

// ----- src/direct_mapped_cache_tag_check.sv -----
// The result strobe out_valid is registered from the commit issued in the
// lookup state that follows the accepting edge. busy is high only in that
// state, which the registered tag RAM read requires, so a new access is
// taken while the previous result is shown. The receiver cannot stall.
// Reset (rst_n low, synchronous): all valid bits and both counters cleared.
`default_nettype none
module direct_mapped_cache_tag_check #(
  parameter int unsigned LINE_BYTES = dmc_pkg::LINE_BYTES_DEF,
  parameter int unsigned NUM_LINES  = dmc_pkg::NUM_LINES_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  output logic              busy,
  input  wire dmc_pkg::in_t in_data,
  output logic              out_valid,
  output dmc_pkg::out_t     out_data
);

  dmc_pkg::ctl_cmd_t cmd;

  dmc_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  dmc_datapath #(
    .LINE_BYTES (LINE_BYTES),
    .NUM_LINES  (NUM_LINES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

// ----- src/dmc_checker.sv -----
`default_nettype none
module dmc_checker (
  input wire logic          clk,
  input wire logic          rst_n,
  input wire logic          start,
  input wire logic          busy,
  input wire logic          out_valid,
  input wire dmc_pkg::out_t out_data
);

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy not raised after transfer");

  a_result_lat: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##2 out_valid)
    else $error("result missing two cycles after transfer");

  a_replace_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.replaced || out_data.mem_read) |->
      out_data.miss && !out_data.mem_write)
    else $error("fill or eviction without read miss");

  a_hit_no_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.miss && !out_data.mem_write |->
      out_data.transfer_bytes == '0 && out_data.evicted_tag == '0)
    else $error("read hit moved data");

endmodule

bind direct_mapped_cache_tag_check dmc_checker u_dmc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);
`default_nettype wire
